// ===== hw/rtl/line_follow_steering_controller_assert.svh =====
// Assertion macros for the line follow steering controller checkers.
// Needs nothing else; include by bare file name.
`ifndef LINE_FOLLOW_STEERING_CONTROLLER_ASSERT_SVH
`define LINE_FOLLOW_STEERING_CONTROLLER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define LFSC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lfsc check failed");

// next-cycle implication, disabled in reset
`define LFSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lfsc check failed");

`endif

// ===== hw/rtl/lfsc_pkg.sv =====
// Package for the line follow steering controller: widths, reset values,
// register indexes and the window result struct. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lfsc_pkg;

   localparam int WINDOW_LEN_DEF = 10;

   localparam int SAMPLE_W  = 12;
   localparam int ERR_W     = 14;
   localparam int SPEED_W   = 17;
   localparam int STEER_W   = 13;
   localparam int CMP_W     = 16;
   localparam int SUM_OUT_W = 18;
   localparam int CNT_OUT_W = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 17;
   localparam int REQ_W     = 40;
   localparam int RSP_W     = 112;

   localparam logic signed [SPEED_W-1:0] BASE_SPEED_RST = '0;
   localparam logic [SAMPLE_W-1:0] LEFT_OFFSET_RST   = 12'd900;
   localparam logic [SAMPLE_W-1:0] MIDDLE_OFFSET_RST = 12'd400;
   localparam logic [SAMPLE_W-1:0] RIGHT_OFFSET_RST  = 12'd1500;
   localparam logic [SAMPLE_W-1:0] BLACK_THR_RST     = 12'd1000;
   localparam logic [STEER_W-1:0]  STEER_THR_RST     = 13'd1500;

   localparam logic signed [31:0] SUM_OUT_MAX = 32'sd131071;
   localparam logic signed [31:0] SUM_OUT_MIN = -32'sd131071;
   localparam logic [7:0]         CNT_OUT_MAX = 8'd15;
   localparam logic signed [18:0] SPEED_MAX   = 19'sd65535;
   localparam logic signed [18:0] SPEED_MIN   = -19'sd65535;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_SPEED    = 3'd0,
      CSR_LEFT_OFFSET   = 3'd1,
      CSR_MIDDLE_OFFSET = 3'd2,
      CSR_RIGHT_OFFSET  = 3'd3,
      CSR_BLACK_THR     = 3'd4,
      CSR_STEER_THR     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic                        updated;
      logic signed [ERR_W-1:0]     error;
      logic signed [SUM_OUT_W-1:0] sum;
      logic [CNT_OUT_W-1:0]        count;
   } win_result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/line_follow_steering_controller.sv =====
// Top level of the line follow steering controller: register bank, window
// stage and steering stage. Depends on lfsc_pkg, lfsc_window, lfsc_steer.
//
// Usage:
//   req_ channel: one beat carries the three line-sensor samples.
//   rsp_ channel: one beat per request beat, in order: updated flag, wheel
//     speeds, direction bits, PWM compare values, error, window sum and
//     middle-only count. A line-lost beat has every field zero.
//   csr_ port: write register csr_index with csr_wdata when csr_wen is high;
//     write only while no request is in flight.
//   Stages: a taken request beat is registered in the window stage, then
//     its result in the response stage; two register stages in all.
//   Throughput: one beat per cycle while not stalled; the window chain shifts
//     and the running sum and count update as a non-lost beat is taken.
//   Reset: synchronous; clears the window, sum, count and position, loads
//     the register reset values and empties both stages.
//   Stall: while rsp_tready is low the result holds; the window stage still
//     takes one more request beat if empty, after which req_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module line_follow_steering_controller #(
   parameter int WINDOW_LEN = lfsc_pkg::WINDOW_LEN_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // left_sample[11:0], middle_sample[23:12], right_sample[35:24], zero pad
   input  wire logic [lfsc_pkg::REQ_W-1:0]         req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // updated[0], left_speed[17:1], right_speed[34:18], left_phase[35],
   // left_compare[51:36], right_phase[52], right_compare[68:53],
   // proportional_error[82:69], window_error_sum[100:83],
   // middle_only_count[104:101], zero pad
   output logic [lfsc_pkg::RSP_W-1:0]              rsp_tdata,
   input  wire logic                               csr_wen,
   input  wire logic [lfsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [lfsc_pkg::CSR_DAT_W-1:0]     csr_wdata
);

   logic signed [lfsc_pkg::SPEED_W-1:0] base_speed_ff;
   logic [lfsc_pkg::SAMPLE_W-1:0]       left_offset_ff, middle_offset_ff, right_offset_ff;
   logic [lfsc_pkg::SAMPLE_W-1:0]       black_thr_ff;
   logic [lfsc_pkg::STEER_W-1:0]        steer_thr_ff;

   lfsc_pkg::win_result_type win_in, win_ff;
   logic                     win_valid_ff, win_ready, rsp_ready, accept;
   logic [lfsc_pkg::RSP_W-1:0] beat_in, rsp_data_ff;
   logic                     rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_speed_ff    <= lfsc_pkg::BASE_SPEED_RST;
         left_offset_ff   <= lfsc_pkg::LEFT_OFFSET_RST;
         middle_offset_ff <= lfsc_pkg::MIDDLE_OFFSET_RST;
         right_offset_ff  <= lfsc_pkg::RIGHT_OFFSET_RST;
         black_thr_ff     <= lfsc_pkg::BLACK_THR_RST;
         steer_thr_ff     <= lfsc_pkg::STEER_THR_RST;
      end else if (csr_wen) begin
         unique case (csr_index)
            lfsc_pkg::CSR_BASE_SPEED:    base_speed_ff    <= $signed(csr_wdata);
            lfsc_pkg::CSR_LEFT_OFFSET:   left_offset_ff   <= csr_wdata[11:0];
            lfsc_pkg::CSR_MIDDLE_OFFSET: middle_offset_ff <= csr_wdata[11:0];
            lfsc_pkg::CSR_RIGHT_OFFSET:  right_offset_ff  <= csr_wdata[11:0];
            lfsc_pkg::CSR_BLACK_THR:     black_thr_ff     <= csr_wdata[11:0];
            lfsc_pkg::CSR_STEER_THR:     steer_thr_ff     <= csr_wdata[12:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_ready  = !rsp_valid_ff || rsp_tready;
   assign win_ready  = !win_valid_ff || rsp_ready;
   assign req_tready = win_ready;
   assign accept     = req_tvalid && win_ready;

   lfsc_window #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_window (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .left_sample     (req_tdata[11:0]),
      .middle_sample   (req_tdata[23:12]),
      .right_sample    (req_tdata[35:24]),
      .left_offset     (left_offset_ff),
      .middle_offset   (middle_offset_ff),
      .right_offset    (right_offset_ff),
      .black_threshold (black_thr_ff),
      .result          (win_in)
   );

   lfsc_steer u_steer (
      .win             (win_ff),
      .base_speed      (base_speed_ff),
      .steer_threshold (steer_thr_ff),
      .beat            (beat_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         win_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (win_ready) begin
            win_valid_ff <= req_tvalid;
         end
         if (rsp_ready) begin
            rsp_valid_ff <= win_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
      if (rsp_ready && win_valid_ff) begin
         rsp_data_ff <= beat_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lfsc_cell.sv =====
// One window cell: holds one error and one middle-only flag, passes them on.
// Depends on lfsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfsc_cell (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               shift_en,
   input  wire logic signed [lfsc_pkg::ERR_W-1:0]  err_in,
   input  wire logic                               mid_in,
   output logic signed [lfsc_pkg::ERR_W-1:0]       err_out,
   output logic                                    mid_out
);

   logic signed [lfsc_pkg::ERR_W-1:0] err_ff;
   logic                              mid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff <= '0;
         mid_ff <= 1'b0;
      end else if (shift_en) begin
         err_ff <= err_in;
         mid_ff <= mid_in;
      end
   end

   assign err_out = err_ff;
   assign mid_out = mid_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lfsc_window.sv =====
// Sample correction, line-lost test and the error window as a chain of cells
// with running sum and middle-only count. Depends on lfsc_pkg, lfsc_cell.
`timescale 1ns / 1ps
`default_nettype none

module lfsc_window #(
   parameter int WINDOW_LEN = lfsc_pkg::WINDOW_LEN_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                accept,
   input  wire logic [lfsc_pkg::SAMPLE_W-1:0]       left_sample,
   input  wire logic [lfsc_pkg::SAMPLE_W-1:0]       middle_sample,
   input  wire logic [lfsc_pkg::SAMPLE_W-1:0]       right_sample,
   input  wire logic [lfsc_pkg::SAMPLE_W-1:0]       left_offset,
   input  wire logic [lfsc_pkg::SAMPLE_W-1:0]       middle_offset,
   input  wire logic [lfsc_pkg::SAMPLE_W-1:0]       right_offset,
   input  wire logic [lfsc_pkg::SAMPLE_W-1:0]       black_threshold,
   output lfsc_pkg::win_result_type                 result
);

   localparam int ERR_W = lfsc_pkg::ERR_W;
   localparam int SUM_W = $clog2(WINDOW_LEN * 8190 + 1) + 1;
   localparam int CNT_W = $clog2(WINDOW_LEN + 1);
   localparam int POS_W = $clog2(WINDOW_LEN);

   logic signed [ERR_W-1:0] l_val, m_val, r_val, thr_val, err_val;
   logic                    l_white, m_white, r_white, lost, shift_en, cur_mid;
   logic signed [ERR_W-1:0] err_tap [WINDOW_LEN+1];
   logic                    mid_tap [WINDOW_LEN+1];
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic signed [31:0]      sum_wide;
   logic [7:0]              cnt_wide;

   assign l_val   = $signed({2'b00, left_sample})   - $signed({2'b00, left_offset});
   assign m_val   = $signed({2'b00, middle_sample}) - $signed({2'b00, middle_offset});
   assign r_val   = $signed({2'b00, right_sample})  - $signed({2'b00, right_offset});
   assign thr_val = $signed({2'b00, black_threshold});
   assign l_white = l_val < thr_val;
   assign m_white = m_val < thr_val;
   assign r_white = r_val < thr_val;
   assign lost    = l_white && m_white && r_white && (pos_ff == '0);
   assign err_val = l_val - r_val;
   assign cur_mid = !m_white && l_white && r_white;
   assign shift_en = accept && !lost;

   assign err_tap[0] = err_val;
   assign mid_tap[0] = cur_mid;

   for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
      lfsc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .err_in   (err_tap[i]),
         .mid_in   (mid_tap[i]),
         .err_out  (err_tap[i+1]),
         .mid_out  (mid_tap[i+1])
      );
   end

   assign sum_in = sum_ff + SUM_W'(err_val) - SUM_W'(err_tap[WINDOW_LEN]);
   assign cnt_in = cnt_ff - CNT_W'(mid_tap[WINDOW_LEN]) + CNT_W'(cur_mid);
   assign pos_in = (pos_ff == POS_W'(WINDOW_LEN - 1)) ? '0 : pos_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
         pos_ff <= '0;
      end else if (shift_en) begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
      end
   end

   assign sum_wide = 32'(sum_in);
   assign cnt_wide = 8'(cnt_in);

   always_comb begin
      result = '0;
      if (!lost) begin
         result.updated = 1'b1;
         result.error   = err_val;
         priority if (sum_wide > lfsc_pkg::SUM_OUT_MAX) begin
            result.sum = lfsc_pkg::SUM_OUT_W'(lfsc_pkg::SUM_OUT_MAX);
         end else if (sum_wide < lfsc_pkg::SUM_OUT_MIN) begin
            result.sum = lfsc_pkg::SUM_OUT_W'(lfsc_pkg::SUM_OUT_MIN);
         end else begin
            result.sum = lfsc_pkg::SUM_OUT_W'(sum_wide);
         end
         result.count = (cnt_wide > lfsc_pkg::CNT_OUT_MAX) ?
                        lfsc_pkg::CNT_OUT_W'(lfsc_pkg::CNT_OUT_MAX) :
                        cnt_wide[lfsc_pkg::CNT_OUT_W-1:0];
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lfsc_steer.sv =====
// Steering: half-error correction, wheel stop, saturation, phase and compare,
// packed into the result beat. Depends on lfsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfsc_steer (
   input  wire lfsc_pkg::win_result_type               win,
   input  wire logic signed [lfsc_pkg::SPEED_W-1:0]    base_speed,
   input  wire logic [lfsc_pkg::STEER_W-1:0]           steer_threshold,
   output logic [lfsc_pkg::RSP_W-1:0]                  beat
);

   localparam int SPEED_W = lfsc_pkg::SPEED_W;

   logic signed [lfsc_pkg::ERR_W-1:0] corr;
   logic signed [14:0]                err_x, st_x;
   logic signed [18:0]                base_x, ls_raw, rs_raw;
   logic signed [SPEED_W-1:0]         ls, rs, ls_neg;
   logic                              lph, rph;

   assign corr   = (win.error + $signed({13'b0, win.error[13]})) >>> 1;
   assign err_x  = 15'(win.error);
   assign st_x   = $signed({2'b00, steer_threshold});
   assign base_x = 19'(base_speed);

   always_comb begin
      ls_raw = base_x - 19'(corr);
      rs_raw = base_x + 19'(corr);
      priority if (err_x >= st_x) begin
         ls_raw = '0;
      end else if (err_x <= -st_x) begin
         rs_raw = '0;
      end
   end

   function automatic logic signed [SPEED_W-1:0] sat(input logic signed [18:0] v);
      logic signed [SPEED_W-1:0] r;
      priority if (v > lfsc_pkg::SPEED_MAX) begin
         r = SPEED_W'(lfsc_pkg::SPEED_MAX);
      end else if (v < lfsc_pkg::SPEED_MIN) begin
         r = SPEED_W'(lfsc_pkg::SPEED_MIN);
      end else begin
         r = SPEED_W'(v);
      end
      return r;
   endfunction

   assign ls     = sat(ls_raw);
   assign rs     = sat(rs_raw);
   assign ls_neg = -ls;
   assign lph    = (ls > 0);
   assign rph    = rs[SPEED_W-1];

   always_comb begin
      beat = '0;
      if (win.updated) begin
         beat[0]       = 1'b1;
         beat[17:1]    = ls;
         beat[34:18]   = rs;
         beat[35]      = lph;
         beat[51:36]   = ls_neg[15:0];
         beat[52]      = rph;
         beat[68:53]   = rs[15:0];
         beat[82:69]   = win.error;
         beat[100:83]  = win.sum;
         beat[104:101] = win.count;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lfsc_checker.sv =====
// Port-level checks on the result channel of the steering controller, bound
// to the top level. Depends on line_follow_steering_controller_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "line_follow_steering_controller_assert.svh"

module lfsc_checker (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [111:0] rsp_tdata
);

   `LFSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `LFSC_ASSERT_NOW(a_lost_zero, clock, reset, rsp_tvalid && !rsp_tdata[0], rsp_tdata == '0)
   `LFSC_ASSERT_NOW(a_lphase, clock, reset, rsp_tvalid && rsp_tdata[35], !rsp_tdata[17] && rsp_tdata[17:1] != '0)
   `LFSC_ASSERT_NOW(a_rcmp, clock, reset, rsp_tvalid, rsp_tdata[68:53] == rsp_tdata[33:18])

endmodule

bind line_follow_steering_controller lfsc_checker u_lfsc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
